// ===== sv/iee_pkg.sv =====
// Shared types and constants for the infix expression evaluator.
// Used by the controller, the datapath, the divider and the top level.
// No dependencies.
`default_nettype none

package iee_pkg;

  localparam int VALUE_WIDTH  = 32;
  localparam int RESULT_WIDTH = 32;
  localparam int SYMBOL_WIDTH = 8;

  localparam logic [SYMBOL_WIDTH-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [SYMBOL_WIDTH-1:0] CHAR_NINE  = 8'h39;
  localparam logic [SYMBOL_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYMBOL_WIDTH-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYMBOL_WIDTH-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [SYMBOL_WIDTH-1:0] CHAR_SLASH = 8'h2F;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_DIVZERO   = 2'd2,
    ST_BADCHAR   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CLS_DIGIT,
    CLS_OPER,
    CLS_BAD
  } sym_class_t;

  typedef enum logic [1:0] {
    RED_ADDSUB,
    RED_MUL,
    RED_DIV
  } red_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_in;
    logic     push_digit;
    logic     push_op;
    logic     set_err;
    status_t  err_code;
    logic     mul_start;
    logic     div_start;
    logic     red_write;
    red_sel_t red_sel;
    logic     emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    sym_class_t cls;
    op_t        new_op;
    logic       last;
    logic [1:0] vcnt;
    logic [1:0] ocnt;
    op_t        top_op;
    status_t    err;
    logic       b_zero;
    logic       div_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/iee_divider.sv =====
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on iee_pkg for VALUE_WIDTH.
`default_nettype none

module iee_divider
  import iee_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [VALUE_WIDTH-1:0] divisor,
  output logic                        done,
  output logic [VALUE_WIDTH-1:0]      quotient
);

  localparam int CW = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] quo_r, quo_nxt;
  logic [VALUE_WIDTH-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   diff;

  always_comb begin
    shifted  = {rem_r, quo_r[VALUE_WIDTH-1]};
    diff     = shifted - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(VALUE_WIDTH - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[VALUE_WIDTH]) begin
        rem_nxt = diff[VALUE_WIDTH-1:0];
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[VALUE_WIDTH-1:0];
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== sv/iee_datapath.sv =====
// Datapath: input latch, value and operator stacks, ALU, multiplier register,
// divider and result register. Depends on iee_pkg and iee_divider.
`default_nettype none

module iee_datapath
  import iee_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [SYMBOL_WIDTH-1:0] in_symbol,
  input  wire logic                    in_last,
  input  wire dp_cmd_t                 cmd,
  output dp_stat_t                     stat,
  output logic [RESULT_WIDTH-1:0]      res_value,
  output status_t                      res_status
);

  // Stacks keep their top at a fixed slot: v0 and o0 are the tops.
  logic [VALUE_WIDTH-1:0]  v0_r, v1_r, v2_r;
  op_t                     o0_r, o1_r;
  logic [1:0]              vcnt_r, ocnt_r;
  status_t                 err_r;
  logic [SYMBOL_WIDTH-1:0] sym_r;
  logic                    last_r;
  logic [VALUE_WIDTH-1:0]  mul_r;
  logic                    neg_r;
  logic [RESULT_WIDTH-1:0] res_value_r;
  status_t                 res_status_r;

  sym_class_t              cls;
  op_t                     new_op;
  logic [SYMBOL_WIDTH-1:0] digit;
  logic [VALUE_WIDTH-1:0]  red_val;
  logic [VALUE_WIDTH-1:0]  mag_a, mag_b;
  logic [VALUE_WIDTH-1:0]  quotient;
  logic                    div_done;
  status_t                 final_st;
  logic signed [63:0]      wide_val;

  always_comb begin
    cls    = CLS_BAD;
    new_op = OP_ADD;
    if (sym_r inside {[CHAR_ZERO:CHAR_NINE]}) begin
      cls = CLS_DIGIT;
    end else begin
      case (sym_r)
        CHAR_PLUS: begin
          cls = CLS_OPER;
          new_op = OP_ADD;
        end
        CHAR_MINUS: begin
          cls = CLS_OPER;
          new_op = OP_SUB;
        end
        CHAR_STAR: begin
          cls = CLS_OPER;
          new_op = OP_MUL;
        end
        CHAR_SLASH: begin
          cls = CLS_OPER;
          new_op = OP_DIV;
        end
        default: begin
          cls = CLS_BAD;
        end
      endcase
    end
  end

  assign digit = sym_r - CHAR_ZERO;
  assign mag_a = v1_r[VALUE_WIDTH-1] ? (~v1_r + 1'b1) : v1_r;
  assign mag_b = v0_r[VALUE_WIDTH-1] ? (~v0_r + 1'b1) : v0_r;

  always_comb begin
    case (cmd.red_sel)
      RED_ADDSUB: red_val = (o0_r == OP_SUB) ? (v1_r - v0_r) : (v1_r + v0_r);
      RED_MUL:    red_val = mul_r;
      RED_DIV:    red_val = neg_r ? (~quotient + 1'b1) : quotient;
      default:    red_val = mul_r;
    endcase
  end

  always_comb begin
    if (err_r != ST_OK) begin
      final_st = err_r;
    end else if (vcnt_r != 2'd1) begin
      final_st = ST_MALFORMED;
    end else begin
      final_st = ST_OK;
    end
  end

  assign wide_val = 64'(signed'(v0_r));

  iee_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (mag_a),
    .divisor  (mag_b),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r <= '0;
      ocnt_r <= '0;
      err_r  <= ST_OK;
    end else begin
      if (cmd.push_digit) begin
        vcnt_r <= vcnt_r + 1'b1;
      end
      if (cmd.push_op) begin
        ocnt_r <= ocnt_r + 1'b1;
      end
      if (cmd.red_write) begin
        vcnt_r <= vcnt_r - 1'b1;
        ocnt_r <= ocnt_r - 1'b1;
      end
      if (cmd.set_err && err_r == ST_OK) begin
        err_r <= cmd.err_code;
      end
      if (cmd.emit) begin
        vcnt_r <= '0;
        ocnt_r <= '0;
        err_r  <= ST_OK;
      end
    end

    if (cmd.load_in) begin
      sym_r  <= in_symbol;
      last_r <= in_last;
    end
    if (cmd.push_digit) begin
      v0_r <= VALUE_WIDTH'(digit[3:0]);
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
    if (cmd.red_write) begin
      v0_r <= red_val;
      v1_r <= v2_r;
      o0_r <= o1_r;
    end
    if (cmd.push_op) begin
      o0_r <= new_op;
      o1_r <= o0_r;
    end
    if (cmd.mul_start) begin
      mul_r <= VALUE_WIDTH'(v1_r * v0_r);
    end
    if (cmd.div_start) begin
      neg_r <= v1_r[VALUE_WIDTH-1] ^ v0_r[VALUE_WIDTH-1];
    end
    if (cmd.emit) begin
      res_value_r  <= (final_st == ST_OK) ? wide_val[RESULT_WIDTH-1:0] : '0;
      res_status_r <= final_st;
    end
  end

  always_comb begin
    stat.cls      = cls;
    stat.new_op   = new_op;
    stat.last     = last_r;
    stat.vcnt     = vcnt_r;
    stat.ocnt     = ocnt_r;
    stat.top_op   = o0_r;
    stat.err      = err_r;
    stat.b_zero   = (v0_r == '0);
    stat.div_done = div_done;
  end

  assign res_value  = res_value_r;
  assign res_status = res_status_r;

endmodule

`default_nettype wire

// ===== sv/iee_controller.sv =====
// Controller state machine: sequences decode, reductions, flush and output.
// Depends on iee_pkg for the command and status structs.
`default_nettype none

module iee_controller
  import iee_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_OPLOOP,
    S_RED,
    S_MULW,
    S_DIVW,
    S_FLUSH,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   ret_flush_r, ret_flush_nxt;
  logic   out_valid_r, out_valid_nxt;
  state_t end_st;
  state_t ret_st;
  logic   err_set;

  always_comb begin
    err_set       = (stat.err != ST_OK);
    end_st        = stat.last ? S_FLUSH : S_IDLE;
    ret_st        = ret_flush_r ? S_FLUSH : S_OPLOOP;
    state_nxt     = state_r;
    ret_flush_nxt = ret_flush_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.err_code  = ST_OK;
    cmd.red_sel   = RED_ADDSUB;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (err_set) begin
          state_nxt = end_st;
        end else begin
          case (stat.cls)
            CLS_DIGIT: begin
              if (stat.vcnt == 2'd3) begin
                cmd.set_err  = 1'b1;
                cmd.err_code = ST_MALFORMED;
              end else begin
                cmd.push_digit = 1'b1;
              end
              state_nxt = end_st;
            end
            CLS_OPER: begin
              state_nxt = S_OPLOOP;
            end
            default: begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_BADCHAR;
              state_nxt    = end_st;
            end
          endcase
        end
      end
      S_OPLOOP: begin
        if (err_set) begin
          state_nxt = end_st;
        end else if (stat.ocnt != 2'd0 && stat.top_op[1] >= stat.new_op[1]) begin
          ret_flush_nxt = 1'b0;
          state_nxt     = S_RED;
        end else if (stat.ocnt == 2'd2) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_MALFORMED;
          state_nxt    = end_st;
        end else begin
          cmd.push_op = 1'b1;
          state_nxt   = end_st;
        end
      end
      S_RED: begin
        if (stat.vcnt < 2'd2) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_MALFORMED;
          state_nxt    = ret_st;
        end else begin
          case (stat.top_op)
            OP_MUL: begin
              cmd.mul_start = 1'b1;
              state_nxt     = S_MULW;
            end
            OP_DIV: begin
              if (stat.b_zero) begin
                cmd.set_err  = 1'b1;
                cmd.err_code = ST_DIVZERO;
                state_nxt    = ret_st;
              end else begin
                cmd.div_start = 1'b1;
                state_nxt     = S_DIVW;
              end
            end
            default: begin
              cmd.red_write = 1'b1;
              cmd.red_sel   = RED_ADDSUB;
              state_nxt     = ret_st;
            end
          endcase
        end
      end
      S_MULW: begin
        cmd.red_write = 1'b1;
        cmd.red_sel   = RED_MUL;
        state_nxt     = ret_st;
      end
      S_DIVW: begin
        if (stat.div_done) begin
          cmd.red_write = 1'b1;
          cmd.red_sel   = RED_DIV;
          state_nxt     = ret_st;
        end
      end
      S_FLUSH: begin
        if (!err_set && stat.ocnt != 2'd0) begin
          ret_flush_nxt = 1'b1;
          state_nxt     = S_RED;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_flush_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_flush_r <= ret_flush_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== sv/infix_expression_evaluator.sv =====
// Top level of the infix expression evaluator: controller plus datapath.
// Depends on iee_pkg, iee_controller and iee_datapath.
//
//   Channel | Direction | Payload
//   in_     | slave     | tdata[7:0] = symbol, tlast = last_symbol
//   out_    | master    | tdata[31:0] = result_value, tuser[1:0] = status
//
// A digit is accepted in S_IDLE and then decoded in S_DECODE. An operator
// also passes S_OPLOOP, which compares binding strengths. Each reduction
// it triggers passes S_RED, then S_MULW for * or S_DIVW for /, which waits
// on the 32-step bit-serial divider. The worst operator triggers a division
// reduction followed by an addition or subtraction reduction.
// The last item flushes the operator stack with the same reductions unless an
// error is set; S_FLUSH then sees the stack empty and S_EMIT loads the result.
// Reset is synchronous and active low; the stacks hold no reset value.
// The result register lets the next expression start while a result waits
// on out_tready; a second result waits until the first one is taken.
`default_nettype none

module infix_expression_evaluator
  import iee_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] symbol
  input  wire logic        in_tlast,   // last_symbol
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] result_value
  output logic [1:0]       out_tuser   // [1:0] status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  status_t  res_status;

  // The controller owns the handshakes and all sequencing decisions.
  iee_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the stacks, the arithmetic and the result register.
  iee_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_symbol  (in_tdata),
    .in_last    (in_tlast),
    .cmd        (cmd),
    .stat       (stat),
    .res_value  (out_tdata),
    .res_status (res_status)
  );

  assign out_tuser = res_status;

  // An error result always carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata == '0))
    else $error("error result with nonzero value");

  // After an item is taken the block works on it before taking another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while previous item in work");

  // A digit is never pushed onto a full value stack.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_digit |-> (stat.vcnt != 2'd3))
    else $error("value stack overflow");

  // A reduction write needs two values and one operator.
  a_reduce_operands: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.red_write |-> (stat.vcnt >= 2'd2 && stat.ocnt != 2'd0))
    else $error("reduction without operands");

endmodule

`default_nettype wire
